// ===== hw/rtl/dsvr_pkg.sv =====
// Shared types, codes and tables for the dual stepper velocity ramp
package dsvr_pkg;

  typedef enum logic [2:0] {
    ACT_SET   = 3'd0,
    ACT_TICK  = 3'd1,
    ACT_STEPL = 3'd2,
    ACT_STEPR = 3'd3,
    ACT_CLEAR = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    REG_ACCEL = 2'd0,
    REG_DECEL = 2'd1,
    REG_NUMER = 2'd2,
    REG_HOLD  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  localparam logic [15:0] START_RELOAD = 16'd20000;
  localparam int          STOP_LIMIT   = 128;
  localparam int          NUM_WIDTH    = 32;
  localparam int          CFG_WIDTH    = 32;
  localparam int          CFG_IDX_W    = 2;

  // control from the top to each lane
  typedef struct packed {
    logic start;    // ramp tick: update speed, launch divide
    logic step;     // step the coils
    logic clear;    // zero the count
    logic set_goal; // load target
    logic hold;
    logic inverted;
  } lane_ctl_t;

  function automatic logic [3:0] coil_pattern(input logic [2:0] ph);
    logic [3:0] p;
    case (ph)
      3'd0: p = 4'b0001;
      3'd1: p = 4'b0011;
      3'd2: p = 4'b0010;
      3'd3: p = 4'b0110;
      3'd4: p = 4'b0100;
      3'd5: p = 4'b1100;
      3'd6: p = 4'b1000;
      3'd7: p = 4'b1001;
      default: p = 4'b0000;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/dsvr_if.sv =====
// Valid/ready channel interfaces for input items and results
interface dsvr_in_if #(parameter int SPEED_WIDTH = 24);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    action;
  logic signed [SPEED_WIDTH-1:0] target_left;
  logic signed [SPEED_WIDTH-1:0] target_right;
  modport source (output valid, action, target_left, target_right, input ready);
  modport sink (input valid, action, target_left, target_right, output ready);
endinterface

interface dsvr_out_if #(parameter int SPEED_WIDTH = 24);
  logic                          valid;
  logic                          ready;
  logic [15:0]                   period_left;
  logic [15:0]                   period_right;
  logic                          run_left;
  logic                          run_right;
  logic                          dir_left;
  logic                          dir_right;
  logic [3:0]                    coils_left;
  logic [3:0]                    coils_right;
  logic signed [SPEED_WIDTH-1:0] speed_left;
  logic signed [SPEED_WIDTH-1:0] speed_right;
  logic signed [31:0]            steps_left;
  logic signed [31:0]            steps_right;
  modport source (output valid, period_left, period_right, run_left, run_right,
                  dir_left, dir_right, coils_left, coils_right, speed_left,
                  speed_right, steps_left, steps_right, input ready);
  modport sink (input valid, period_left, period_right, run_left, run_right,
                dir_left, dir_right, coils_left, coils_right, speed_left,
                speed_right, steps_left, steps_right, output ready);
endinterface

// ===== hw/rtl/dsvr_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle
module dsvr_div
  import dsvr_pkg::*;
#(
  parameter int DEN_WIDTH = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] numer,
  input  logic [DEN_WIDTH-1:0] denom,
  output logic                 busy,
  output logic [NUM_WIDTH-1:0] quot
);
  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic [DEN_WIDTH:0]   rem;
  logic [DEN_WIDTH-1:0] den;
  logic [NUM_WIDTH-1:0] qsh;
  logic [CW-1:0]        count;
  logic [DEN_WIDTH:0]   trial;
  logic [DEN_WIDTH:0]   diff;

  assign trial = {rem[DEN_WIDTH-1:0], qsh[NUM_WIDTH-1]};
  assign diff  = trial - {1'b0, den};
  assign quot  = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CW'(NUM_WIDTH);
      rem   <= '0;
      den   <= denom;
      qsh   <= numer;
    end else if (busy) begin
      if (!diff[DEN_WIDTH]) begin
        rem <= diff;
        qsh <= {qsh[NUM_WIDTH-2:0], 1'b1};
      end else begin
        rem <= trial;
        qsh <= {qsh[NUM_WIDTH-2:0], 1'b0};
      end
      count <= count - 1'b1;
      if (count == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ===== hw/rtl/dsvr_lane.sv =====
// One wheel: ramp, period divide, phase sequencer and step count
module dsvr_lane
  import dsvr_pkg::*;
#(
  parameter int SPEED_WIDTH = 24,
  parameter int PERIOD_MIN  = 150,
  parameter int PERIOD_MAX  = 60000
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lane_ctl_t                     ctl,
  input  logic signed [SPEED_WIDTH-1:0] target,
  input  logic [15:0]                   accel_step,
  input  logic [15:0]                   decel_step,
  input  logic [NUM_WIDTH-1:0]          period_numerator,
  output logic                          busy,
  output logic [15:0]                   reload,
  output logic                          running,
  output logic                          fwd,
  output logic [3:0]                    drive,
  output logic signed [SPEED_WIDTH-1:0] ramp,
  output logic signed [31:0]            count
);
  localparam int SW = SPEED_WIDTH;

  logic signed [SW-1:0] goal;
  logic [2:0]           phase;
  logic                 div_busy;
  logic                 div_pend;
  logic                 div_start;
  logic [NUM_WIDTH-1:0] quot;
  logic [SW-1:0]        mag_q;

  // ramp arithmetic one bit wider to avoid overflow
  logic signed [SW:0] cur_x, goal_x, diff_x, step_x, ramp_next_x;
  logic [SW:0]        mag_cur, mag_goal, mag_diff;
  logic               toward_zero;
  logic               stop;
  logic               fwd_new;
  logic [SW-1:0]      mag_new;

  assign cur_x    = {ramp[SW-1], ramp};
  assign goal_x   = {goal[SW-1], goal};
  assign diff_x   = goal_x - cur_x;
  assign mag_cur  = cur_x[SW] ? -cur_x : cur_x;
  assign mag_goal = goal_x[SW] ? -goal_x : goal_x;
  assign mag_diff = diff_x[SW] ? -diff_x : diff_x;
  assign toward_zero = (mag_goal < mag_cur) ||
                       (goal_x < 0 && cur_x > 0) || (goal_x > 0 && cur_x < 0);
  assign step_x = toward_zero ? (SW+1)'(decel_step) : (SW+1)'(accel_step);

  always_comb begin
    if (mag_diff < step_x) ramp_next_x = goal_x;
    else if (diff_x > 0)   ramp_next_x = cur_x + step_x;
    else                   ramp_next_x = cur_x - step_x;
  end

  assign mag_new = ramp_next_x[SW] ? SW'(-ramp_next_x) : SW'(ramp_next_x);
  assign stop    = mag_new < SW'(STOP_LIMIT);
  assign fwd_new = (!ramp_next_x[SW]) != ctl.inverted;
  assign div_start = ctl.start && !stop;

  dsvr_div #(.DEN_WIDTH(SW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (period_numerator),
    .denom (mag_new),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign busy = div_busy;

  // clamp q-1 into the period window
  logic [15:0] clamped;
  always_comb begin
    if (quot == '0 || (quot - 1'b1) < NUM_WIDTH'(PERIOD_MIN))
      clamped = 16'(PERIOD_MIN);
    else if ((quot - 1'b1) > NUM_WIDTH'(PERIOD_MAX))
      clamped = 16'(PERIOD_MAX);
    else
      clamped = 16'(quot - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal     <= '0;
      ramp     <= '0;
      reload   <= START_RELOAD;
      phase    <= '0;
      fwd      <= 1'b1;
      running  <= 1'b0;
      drive    <= '0;
      count    <= '0;
      div_pend <= 1'b0;
    end else begin
      if (ctl.set_goal) goal <= target;
      if (ctl.clear) count <= '0;
      if (ctl.start) begin
        ramp <= SW'(ramp_next_x);
        if (stop) begin
          running <= 1'b0;
          if (!ctl.hold) drive <= '0;
        end else begin
          fwd <= fwd_new;
          if (!running) begin
            phase    <= fwd_new ? 3'd1 : 3'd7;
            running  <= 1'b1;
            reload   <= START_RELOAD;
          end else begin
            div_pend <= 1'b1;
          end
        end
      end else if (div_pend && !div_busy) begin
        reload   <= clamped;
        div_pend <= 1'b0;
      end
      if (ctl.step && running) begin
        drive <= coil_pattern(phase);
        phase <= fwd ? phase + 3'd1 : phase - 3'd1;
        count <= (fwd != ctl.inverted) ? count + 32'sd1 : count - 32'sd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_drive_off_stop: assert property (@(posedge clk) disable iff (rst)
    ctl.start && stop && !ctl.hold |=> drive == '0)
    else $error("coils not released on stop");
  a_div_idle_pend: assert property (@(posedge clk) disable iff (rst)
    div_pend && !ctl.start |-> running)
    else $error("period pending on stopped wheel");
  a_start_reload: assert property (@(posedge clk) disable iff (rst)
    ctl.start && !stop && !running |=> reload == START_RELOAD && running)
    else $error("start reload missing");
`endif
endmodule

// ===== hw/rtl/dual_stepper_velocity_ramp.sv =====
// Top level of the two-wheel stepper speed ramp
//
//  channel | dir | handshake     | payload
//  in      | in  | valid/ready   | action, target_left, target_right
//  res     | out | valid/ready   | period, run, dir, coils, speed, steps per wheel
//  cfg     | in  | cfg_we        | cfg_index, cfg_data (accel, decel, numerator, hold)
//
// Tick: each lane whose new speed is at or above the stop limit runs the 32-step
// divider, and the result is shown once both dividers are idle.
// One item in flight; in.ready returns the cycle after the result transfer.
// The result holds while res.ready is low.
// rst is synchronous; it restores the control, state and config registers to their reset values.
module dual_stepper_velocity_ramp
  import dsvr_pkg::*;
#(
  parameter int SPEED_WIDTH = 24,
  parameter int PERIOD_MIN  = 150,
  parameter int PERIOD_MAX  = 60000
) (
  input  logic                 clk,
  input  logic                 rst,
  dsvr_in_if.sink              in,
  dsvr_out_if.source           res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);
  logic [15:0]          accel_step, decel_step;
  logic [NUM_WIDTH-1:0] period_numerator;
  logic                 hold_at_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_step       <= 16'd512;
      decel_step       <= 16'd512;
      period_numerator <= 32'd104682000;
      hold_at_zero     <= 1'b0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_ACCEL: accel_step       <= cfg_data[15:0];
        REG_DECEL: decel_step       <= cfg_data[15:0];
        REG_NUMER: period_numerator <= cfg_data;
        REG_HOLD:  hold_at_zero     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic   xfer_in;
  logic   lanes_busy;
  logic   busy_l, busy_r;
  logic   settle;  // registered xfer_in; masks the gap before the divider reports busy

  assign xfer_in    = in.valid && in.ready;
  assign lanes_busy = busy_l || busy_r || settle;

  lane_ctl_t ctl_l, ctl_r;
  always_comb begin
    ctl_l = '0;
    ctl_r = '0;
    ctl_l.inverted = 1'b1;
    ctl_l.hold = hold_at_zero;
    ctl_r.hold = hold_at_zero;
    if (xfer_in) begin
      case (action_t'(in.action))
        ACT_SET:   begin ctl_l.set_goal = 1'b1; ctl_r.set_goal = 1'b1; end
        ACT_TICK:  begin ctl_l.start = 1'b1;    ctl_r.start = 1'b1;    end
        ACT_STEPL: ctl_l.step = 1'b1;
        ACT_STEPR: ctl_r.step = 1'b1;
        ACT_CLEAR: begin ctl_l.clear = 1'b1;    ctl_r.clear = 1'b1;    end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (xfer_in) state_next = ST_DIV;
      ST_DIV:  if (!lanes_busy) state_next = ST_OUT;
      ST_OUT:  if (res.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in.ready  = (state == ST_IDLE);
    res.valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      settle <= 1'b0;
    end else begin
      state  <= state_next;
      settle <= xfer_in;
    end
  end

  // lanes write their state registers, which double as the result register;
  // the reload lands in the cycle after the divider goes idle, covered by ST_DIV->ST_OUT
  logic [15:0]                   reload_l, reload_r;
  logic signed [SPEED_WIDTH-1:0] ramp_l, ramp_r;
  logic signed [31:0]            count_l, count_r;
  logic                          run_l, run_r, fwd_l, fwd_r;
  logic [3:0]                    drive_l, drive_r;

  dsvr_lane #(.SPEED_WIDTH(SPEED_WIDTH), .PERIOD_MIN(PERIOD_MIN),
              .PERIOD_MAX(PERIOD_MAX)) u_left (
    .clk(clk), .rst(rst), .ctl(ctl_l), .target(in.target_left),
    .accel_step(accel_step), .decel_step(decel_step),
    .period_numerator(period_numerator), .busy(busy_l), .reload(reload_l),
    .running(run_l), .fwd(fwd_l), .drive(drive_l), .ramp(ramp_l), .count(count_l)
  );

  dsvr_lane #(.SPEED_WIDTH(SPEED_WIDTH), .PERIOD_MIN(PERIOD_MIN),
              .PERIOD_MAX(PERIOD_MAX)) u_right (
    .clk(clk), .rst(rst), .ctl(ctl_r), .target(in.target_right),
    .accel_step(accel_step), .decel_step(decel_step),
    .period_numerator(period_numerator), .busy(busy_r), .reload(reload_r),
    .running(run_r), .fwd(fwd_r), .drive(drive_r), .ramp(ramp_r), .count(count_r)
  );

  // merge: both lanes' registers form the result word, stable in ST_OUT
  assign res.period_left  = reload_l;
  assign res.period_right = reload_r;
  assign res.run_left     = run_l;
  assign res.run_right    = run_r;
  assign res.dir_left     = fwd_l;
  assign res.dir_right    = fwd_r;
  assign res.coils_left   = drive_l;
  assign res.coils_right  = drive_r;
  assign res.speed_left   = ramp_l;
  assign res.speed_right  = ramp_r;
  assign res.steps_left   = count_l;
  assign res.steps_right  = count_r;

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    lanes_busy && !settle |-> !in.ready)
    else $error("input taken while lanes busy");
  a_out_idle_lanes: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !busy_l && !busy_r)
    else $error("result shown while dividing");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> $stable(res.period_left) && $stable(res.period_right))
    else $error("result changed under stall");
`endif
endmodule

// ===== dv/dsvr_tb_pkg.sv =====
// Stimulus item and expected-result types for the stepper ramp bench
package dsvr_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [23:0] target_left;
    logic signed [23:0] target_right;
  } ramp_cmd_t;

  typedef struct packed {
    logic [15:0]        period_left;
    logic [15:0]        period_right;
    logic               run_left;
    logic               run_right;
    logic               dir_left;
    logic               dir_right;
    logic [3:0]         coils_left;
    logic [3:0]         coils_right;
    logic signed [23:0] speed_left;
    logic signed [23:0] speed_right;
    logic signed [31:0] steps_left;
    logic signed [31:0] steps_right;
  } wheel_state_t;
endpackage

// ===== dv/testbench.sv =====
// Self-checking bench for dual_stepper_velocity_ramp
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dsvr_pkg::*;
  import dsvr_tb_pkg::*;

  localparam int SW = 24;
  localparam int LIMIT = 2000000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  dsvr_in_if #(.SPEED_WIDTH(SW)) cmd_ch ();
  dsvr_out_if #(.SPEED_WIDTH(SW)) st_ch ();

  dual_stepper_velocity_ramp dut (
    .clk(clk), .rst(rst), .in(cmd_ch.sink), .res(st_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: register copies plus per-wheel motion state
  // ---------------------------------------------------------------------------
  logic [15:0] m_accel, m_decel;
  logic [31:0] m_numer;
  logic        m_hold;
  logic signed [23:0] goal_l, goal_r;
  wheel_state_t whl;   // current outputs double as state
  logic [2:0] ph_l, ph_r;

  ramp_cmd_t    pending_cmds[$];
  wheel_state_t expected_states[$];
  int errors = 0;
  int cycles = 0;

  function automatic longint absl(longint x);
    return x < 0 ? -x : x;
  endfunction

  // one ramp step of a wheel speed toward its goal
  function automatic logic signed [23:0] ramp_toward(logic signed [23:0] cur,
                                                     logic signed [23:0] goal);
    longint c, g, stp;
    logic slow;
    c = cur;
    g = goal;
    slow = (absl(g) < absl(c)) || (g < 0 && c > 0) || (g > 0 && c < 0);
    stp = slow ? longint'(m_decel) : longint'(m_accel);
    if (absl(g - c) < stp) return goal;
    return 24'(g > c ? c + stp : c - stp);
  endfunction

  // speed to timer reload, direction, start and stop handling
  task automatic update_wheel(input logic signed [23:0] spd, input logic inv,
                              inout logic [15:0] reload, inout logic [2:0] ph,
                              inout logic fwd, inout logic run,
                              inout logic [3:0] coils);
    longint a, q;
    a = absl(longint'(spd));
    if (a < STOP_LIMIT) begin
      run = 0;
      if (!m_hold) coils = 0;
    end else begin
      fwd = (spd >= 0) != inv;
      q = longint'(m_numer) / a;
      if (q == 0 || q - 1 < 150) reload = 150;
      else if (q - 1 > 60000) reload = 60000;
      else reload = 16'(q - 1);
      if (!run) begin
        ph = fwd ? 3'd1 : 3'd7;
        reload = START_RELOAD;
        run = 1;
      end
    end
  endtask

  task automatic step_wheel(inout logic [2:0] ph, input logic fwd,
                            inout logic [3:0] coils, inout logic signed [31:0] cnt,
                            input logic inv);
    logic [3:0] pat [8];
    pat = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
    coils = pat[ph];
    ph = fwd ? ph + 3'd1 : ph - 3'd1;
    cnt = (fwd != inv) ? cnt + 1 : cnt - 1;
  endtask

  task automatic predict_motion(input ramp_cmd_t c);
    case (c.action)
      ACT_SET: begin
        goal_l = c.target_left;
        goal_r = c.target_right;
      end
      ACT_TICK: begin
        whl.speed_left = ramp_toward(whl.speed_left, goal_l);
        whl.speed_right = ramp_toward(whl.speed_right, goal_r);
        update_wheel(whl.speed_left, 1'b1, whl.period_left, ph_l, whl.dir_left,
                     whl.run_left, whl.coils_left);
        update_wheel(whl.speed_right, 1'b0, whl.period_right, ph_r, whl.dir_right,
                     whl.run_right, whl.coils_right);
      end
      ACT_STEPL: if (whl.run_left)
        step_wheel(ph_l, whl.dir_left, whl.coils_left, whl.steps_left, 1'b1);
      ACT_STEPR: if (whl.run_right)
        step_wheel(ph_r, whl.dir_right, whl.coils_right, whl.steps_right, 1'b0);
      ACT_CLEAR: begin
        whl.steps_left = 0;
        whl.steps_right = 0;
      end
      default: ;
    endcase
    expected_states.push_back(whl);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts and gaps, inputs change on the falling edge
  // ---------------------------------------------------------------------------
  int burst_left = 0, gap_left = 0;
  logic pause_sender = 0;
  logic in_xfer = 0;  // input transfer at the last rising edge

  initial begin
    cmd_ch.valid = 0;
    cmd_ch.action = '0;
    cmd_ch.target_left = '0;
    cmd_ch.target_right = '0;
  end

  always @(posedge clk) in_xfer <= cmd_ch.valid && cmd_ch.ready;

  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 0;
    end else if (!cmd_ch.valid || in_xfer) begin
      // previous transfer done (or nothing held): choose next
      if (pause_sender || pending_cmds.size() == 0) begin
        cmd_ch.valid <= 0;
      end else if (gap_left > 0) begin
        gap_left--;
        cmd_ch.valid <= 0;
      end else begin
        ramp_cmd_t c;
        c = pending_cmds.pop_front();
        cmd_ch.valid <= 1;
        cmd_ch.action <= c.action;
        cmd_ch.target_left <= c.target_left;
        cmd_ch.target_right <= c.target_right;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end
    end
  end

  // Receiver stall pattern: alternating stalled windows and mostly open windows with random ready
  int stall_cnt = 0;
  logic stall_mode = 0;
  initial st_ch.ready = 0;
  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= ~stall_mode;
      stall_cnt <= stall_mode ? $urandom_range(5, 40) : $urandom_range(1, 8);
      st_ch.ready <= stall_mode;
    end else begin
      stall_cnt <= stall_cnt - 1;
      if (!stall_mode) st_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input transfers, check on result transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        ramp_cmd_t c;
        c.action = cmd_ch.action;
        c.target_left = cmd_ch.target_left;
        c.target_right = cmd_ch.target_right;
        predict_motion(c);
      end
      if (st_ch.valid && st_ch.ready) begin
        wheel_state_t got, want;
        got = '{st_ch.period_left, st_ch.period_right, st_ch.run_left,
                st_ch.run_right, st_ch.dir_left, st_ch.dir_right, st_ch.coils_left,
                st_ch.coils_right, st_ch.speed_left, st_ch.speed_right,
                st_ch.steps_left, st_ch.steps_right};
        if (expected_states.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer %p", got);
        end else begin
          want = expected_states.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[dual_stepper_velocity_ramp] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic ramp_cmd_t mk(logic [2:0] act, int tl = 0, int tr = 0);
    ramp_cmd_t c;
    c.action = act;
    c.target_left = 24'(tl);
    c.target_right = 24'(tr);
    return c;
  endfunction

  function automatic int rand_speed();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 300) - 150;           // around the stop limit
      1: return $signed(24'($urandom));                 // full range
      2: return 0;
      default: return int'($urandom_range(0, 16000)) - 8000;
    endcase
  endfunction

  task automatic cfg_write(input reg_index_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ACCEL: m_accel = val[15:0];
      REG_DECEL: m_decel = val[15:0];
      REG_NUMER: m_numer = val;
      REG_HOLD:  m_hold = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // let every queued item pass and its result arrive
  task automatic drain();
    while (pending_cmds.size() != 0 || cmd_ch.valid || expected_states.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) pending_cmds.push_back(mk(ACT_SET, rand_speed(), rand_speed()));
      else if (r < 45) pending_cmds.push_back(mk(ACT_TICK));
      else if (r < 68) pending_cmds.push_back(mk(ACT_STEPL));
      else if (r < 91) pending_cmds.push_back(mk(ACT_STEPR));
      else if (r < 95) pending_cmds.push_back(mk(ACT_CLEAR));
      else pending_cmds.push_back(mk(3'($urandom_range(5, 7)),
                                     $urandom, $urandom));
    end
  endtask

  initial begin
    m_accel = 512; m_decel = 512; m_numer = 104682000; m_hold = 0;
    goal_l = 0; goal_r = 0; ph_l = 0; ph_r = 0;
    whl = '0;
    whl.period_left = START_RELOAD;
    whl.period_right = START_RELOAD;
    whl.dir_left = 1;
    whl.dir_right = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: steps while stopped, start both ways, sign flip, stop, extremes
    pending_cmds.push_back(mk(ACT_STEPL));
    pending_cmds.push_back(mk(ACT_STEPR));
    pending_cmds.push_back(mk(ACT_SET, 1000, -1000));
    repeat (3) pending_cmds.push_back(mk(ACT_TICK));
    pending_cmds.push_back(mk(ACT_STEPL));
    pending_cmds.push_back(mk(ACT_STEPR));
    pending_cmds.push_back(mk(ACT_STEPL));
    pending_cmds.push_back(mk(ACT_SET, -700, 700));
    repeat (3) pending_cmds.push_back(mk(ACT_TICK));
    pending_cmds.push_back(mk(ACT_STEPR));
    pending_cmds.push_back(mk(ACT_CLEAR));
    pending_cmds.push_back(mk(ACT_SET, 8388607, -8388608));
    pending_cmds.push_back(mk(ACT_TICK));
    pending_cmds.push_back(mk(ACT_SET, 127, -127));
    repeat (3) pending_cmds.push_back(mk(ACT_TICK));
    pending_cmds.push_back(mk(3'd5, -1, -1));
    pending_cmds.push_back(mk(3'd7));
    drain();

    // extreme registers: huge accel step, unit decel step, tiny numerator, hold on
    cfg_write(REG_ACCEL, 16'hFFFF);
    cfg_write(REG_DECEL, 16'd1);
    cfg_write(REG_NUMER, 32'd1);
    cfg_write(REG_HOLD, 32'd1);
    pending_cmds.push_back(mk(ACT_SET, 8388607, -8388608));
    repeat (4) pending_cmds.push_back(mk(ACT_TICK));
    random_phase(200);
    drain();

    cfg_write(REG_ACCEL, 16'd1);
    cfg_write(REG_DECEL, 16'hFFFF);
    cfg_write(REG_NUMER, 32'hFFFF_FFFF);
    cfg_write(REG_HOLD, 32'd0);
    random_phase(200);
    // let part of the phase go out, then hold off until everything is back
    repeat (1500) @(posedge clk);
    pause_sender = 1;
    while (expected_states.size() != 0 || cmd_ch.valid) @(posedge clk);
    pause_sender = 0;
    drain();

    cfg_write(REG_ACCEL, $urandom_range(64, 4000));
    cfg_write(REG_DECEL, $urandom_range(64, 4000));
    cfg_write(REG_NUMER, $urandom_range(1000000, 300000000));
    cfg_write(REG_HOLD, 32'd1);
    random_phase(300);
    drain();

    cfg_write(REG_ACCEL, 16'd512);
    cfg_write(REG_DECEL, 16'd300);
    cfg_write(REG_NUMER, 32'd104682000);
    cfg_write(REG_HOLD, 32'd0);
    random_phase(300);
    drain();

    if (errors == 0) $display("[dual_stepper_velocity_ramp] OK");
    else $display("[dual_stepper_velocity_ramp] ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/dsvr_pkg.sv
hw/rtl/dsvr_if.sv
hw/rtl/dsvr_div.sv
hw/rtl/dsvr_lane.sv
hw/rtl/dual_stepper_velocity_ramp.sv
dv/dsvr_tb_pkg.sv
dv/testbench.sv
